/* rtl/salc_pkg.sv */
package salc_pkg;

    localparam int SETS = 256;
    localparam int WAYS = 4;
    localparam int IB = (SETS <= 1) ? 1 : $clog2(SETS);
    localparam int IBR = (SETS <= 1) ? 0 : $clog2(SETS);
    localparam int WB = (WAYS <= 1) ? 1 : $clog2(WAYS);

    localparam logic [1:0] KIND_WB = 2'd0;
    localparam logic [1:0] KIND_FETCH = 2'd1;
    localparam logic [1:0] KIND_RESP = 2'd2;

    localparam logic CFG_OFFSET = 1'b0;
    localparam logic CFG_NEXT = 1'b1;

    typedef struct packed {
        logic        is_write;
        logic [31:0] addr;
        logic [IB-1:0] set;
        logic [31:0] tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic        hit;
        logic        last;
    } res_t;

    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [3:0]  rank;
        logic [31:0] tag;
        logic [31:0] addr;
    } line_t;

endpackage

/* rtl/salc_front.sv */
module salc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [31:0]          address,
    input  logic [3:0]           offset_bits,
    output logic                 q_valid,
    input  logic                 q_pop,
    output salc_pkg::req_t       q_data
);
    // two-entry queue of classified requests
    salc_pkg::req_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic rd_reg, wr_reg;
    salc_pkg::req_t req;
    logic [31:0] sh;
    logic [salc_pkg::IB-1:0] fld;
    logic push;

    always_comb
    begin
        sh = address >> offset_bits;
        fld = '0;
        if (salc_pkg::IBR > 0)
            fld = sh[salc_pkg::IB-1:0];
        if ({1'b0, fld} >= (salc_pkg::IB+1)'(salc_pkg::SETS))
            fld = fld - salc_pkg::IB'(salc_pkg::SETS);
        req.is_write = action;
        req.addr = address;
        req.set = fld;
        req.tag = 32'(({32'b0, address}) >> ({2'b0, offset_bits} + 6'(salc_pkg::IBR)));
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (q_pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

/* rtl/salc_back.sv */
module salc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  salc_pkg::req_t       q_data,
    input  logic                 has_next_level,
    output logic                 out_valid,
    input  logic                 out_stall,
    output salc_pkg::res_t       out_data
);
    localparam int W = salc_pkg::WAYS;
    localparam int LCB = $clog2(salc_pkg::SETS + 1);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL, S_WB, S_FETCH, S_RESP, S_WRITE}
        state_t;

    // all ways of one set live in one memory word
    typedef salc_pkg::line_t [W-1:0] set_t;

    state_t state_reg;
    set_t mem [salc_pkg::SETS];
    set_t rd_reg;
    set_t wr_reg;
    salc_pkg::req_t req_reg;
    logic [LCB-1:0] clr_reg;
    logic hit_reg, wb_reg;
    logic [31:0] wb_addr_reg;
    logic wen_reg;
    salc_pkg::res_t out_reg;
    logic out_valid_reg;

    // evaluation of the set
    salc_pkg::line_t nl [W];
    logic hit;
    logic wb;
    logic [31:0] wb_addr;
    always_comb
    begin
        int found, vic, slot, vc;
        logic [3:0] r;
        found = -1; vic = 0; slot = -1; vc = 0;
        r = 4'd0;
        for (int j = 0; j < W; j++)
        begin
            nl[j] = rd_reg[j];
            if (found < 0 && rd_reg[j].valid && rd_reg[j].tag == req_reg.tag)
                found = j;
            if (rd_reg[j].valid)
                vc++;
            if (rd_reg[j].rank > rd_reg[vic].rank)
                vic = j;
        end
        hit = (found >= 0);
        wb = 1'b0;
        wb_addr = rd_reg[vic].addr;
        if (hit)
        begin
            r = rd_reg[found].rank;
            for (int j = 0; j < W; j++)
                if (j != found && rd_reg[j].valid && rd_reg[j].rank < r)
                    nl[j].rank = rd_reg[j].rank + 4'd1;
            nl[found].rank = 4'd0;
            nl[found].addr = req_reg.addr;
            if (req_reg.is_write)
                nl[found].dirty = 1'b1;
        end
        else
        begin
            if (vc == W)
            begin
                wb = has_next_level && rd_reg[vic].dirty;
                nl[vic].valid = 1'b0;
            end
            for (int j = 0; j < W; j++)
                if (slot < 0 && !nl[j].valid)
                    slot = j;
            if (slot < 0)
                slot = 0;
            for (int j = 0; j < W; j++)
                if (j != slot && nl[j].valid && nl[j].rank != 4'd15)
                    nl[j].rank = nl[j].rank + 4'd1;
            nl[slot].valid = 1'b1;
            nl[slot].dirty = req_reg.is_write;
            nl[slot].tag = req_reg.tag;
            nl[slot].addr = req_reg.addr;
            nl[slot].rank = 4'd0;
        end
    end

    logic out_free;
    logic out_load;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = out_free && ((state_reg == S_WB && !hit_reg && wb_reg) ||
                                   (state_reg == S_FETCH && !hit_reg && has_next_level) ||
                                   (state_reg == S_RESP));
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign q_pop = (state_reg == S_IDLE) && q_valid;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
            rd_reg <= mem[req_reg.set];
        if (state_reg == S_CLEAR)
            mem[clr_reg[salc_pkg::IB-1:0]] <= '0;
        else if (wen_reg)
            mem[req_reg.set] <= wr_reg;
        if (state_reg == S_EVAL)
        begin
            for (int j = 0; j < W; j++)
                wr_reg[j] <= nl[j];
            hit_reg <= hit;
            wb_reg <= wb;
            wb_addr_reg <= wb_addr;
        end
        if (q_pop)
            req_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            wen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            wen_reg <= (state_reg == S_RESP) && out_free;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LCB'(salc_pkg::SETS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (q_valid)
                        state_reg <= S_READ;
                S_READ:
                    state_reg <= S_EVAL;
                S_EVAL:
                    state_reg <= S_WB;
                S_WB:
                    if (out_free)
                    begin
                        if (!hit_reg && wb_reg)
                            out_reg <= '{salc_pkg::KIND_WB, wb_addr_reg, 1'b0, 1'b0};
                        state_reg <= S_FETCH;
                    end
                S_FETCH:
                    if (out_free)
                    begin
                        if (!hit_reg && has_next_level)
                            out_reg <= '{salc_pkg::KIND_FETCH, req_reg.addr, 1'b0, 1'b0};
                        state_reg <= S_RESP;
                    end
                S_RESP:
                    if (out_free)
                    begin
                        out_reg <= '{salc_pkg::KIND_RESP, req_reg.addr, hit_reg, 1'b1};
                        state_reg <= S_WRITE;
                    end
                S_WRITE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/set_assoc_lru_writeback_cache_unit.sv */
// sequence: the back part pops a request, reads its set, evaluates it, offers up to
// three output beats (write-back, fetch, response), each held while the output stalls,
// and writes the set into the line memory; it pops no new request before the last one
// is through, while the front queue holds up to two waiting requests
// reset: asynchronous active low; then a clearing pass over all SETS sets
// (256) zeroes the line memory before any access is started
module set_assoc_lru_writeback_cache_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] address_res,
    output logic        hit,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);
    logic [3:0] offset_reg;
    logic next_reg;
    logic q_valid, q_pop;
    salc_pkg::req_t q_data;
    salc_pkg::res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 4'd5;
            next_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                salc_pkg::CFG_OFFSET: offset_reg <= cfg_data;
                salc_pkg::CFG_NEXT:   next_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    salc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .address(address), .offset_bits(offset_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );

    salc_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .has_next_level(next_reg), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(res)
    );

    assign kind = res.kind;
    assign address_res = res.addr;
    assign hit = res.hit;
    assign last = res.last;
endmodule

/* rtl/salc_checker.sv */
module salc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic        hit,
    input logic        last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind))
        else $error("stalled result changed");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (kind == salc_pkg::KIND_RESP)))
        else $error("last flag mismatch");
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != salc_pkg::KIND_RESP |-> !hit)
        else $error("hit on non-response");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind != 2'd3)
        else $error("bad kind");
endmodule

bind set_assoc_lru_writeback_cache_unit salc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .hit(hit), .last(last)
);
